@@ rtl/nmea_sentence_parser_core_defines.svh @@
// Assertion macros for the NMEA sentence parser core.
// Included by the top level; relies on its clock and reset ports.
`ifndef NMEA_SENTENCE_PARSER_CORE_DEFINES_SVH
`define NMEA_SENTENCE_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NSP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("NMEA parser check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define NSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("NMEA parser check failed in the following cycle");

`endif

@@ rtl/nmea_sp_pkg.sv @@
// Shared types and constants for the NMEA sentence parser core.
// No dependencies; used by nmea_sp_step and nmea_sentence_parser_core.
package nmea_sp_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [3:0] CODE_UNKNOWN = 4'd0;
   localparam logic [3:0] CODE_GSV     = 4'd4;
   localparam logic [3:0] CODE_ZDA     = 4'd7;
   localparam logic [3:0] CODE_TXT     = 4'd8;

   localparam logic [6:0] REQUIRED_MASK_RESET = 7'h7F;

   localparam logic [7:0][23:0] NAME_TABLE =
      {"TXT", "ZDA", "VTG", "GLL", "GSV", "RMC", "GSA", "GGA"};

   typedef struct packed {
      logic        starts_dollar;
      logic [15:0] char_window;
      logic [7:0]  code_hits;
      logic [7:0]  dec_accum;
      logic        dec_stopped;
      logic [7:0]  hex_accum;
      logic        hex_stopped;
   } field_type;

   typedef struct packed {
      logic [7:0] running_xor;
      logic       after_asterisk;
      logic [7:0] field_count;
      logic [3:0] current_code;
      logic [7:0] gsv_total;
      logic [7:0] gsv_number;
      logic [6:0] seen_mask;
      field_type  field;
   } state_type;

   typedef struct packed {
      logic       event_kind;
      logic [3:0] sentence_code;
      logic [7:0] field_index;
      logic [7:0] field_value;
      logic       checksum_ok;
      logic       data_ready;
      logic       unknown_sentence;
   } result_type;

endpackage

@@ rtl/nmea_sp_step.sv @@
// Per-character update of the NMEA parser state and the result it produces.
// Depends on nmea_sp_pkg for the state, field and result types.
module nmea_sp_step (
   input  nmea_sp_pkg::state_type  cur_state,
   input  logic [7:0]              rx_byte,
   input  logic [6:0]              required_mask,
   output nmea_sp_pkg::state_type  nxt_state,
   output logic                    has_result,
   output nmea_sp_pkg::result_type result
);

   function automatic nmea_sp_pkg::field_type add_char(nmea_sp_pkg::field_type f,
                                                      logic [7:0] b);
      nmea_sp_pkg::field_type r;
      logic [3:0]             d;
      logic                   dv;
      r = f;
      for (int k = 0; k < 8; k++) begin
         if ({f.char_window, b} == nmea_sp_pkg::NAME_TABLE[k]) begin
            r.code_hits[k] = 1'b1;
         end
      end
      r.char_window = {f.char_window[7:0], b};
      if (!f.dec_stopped) begin
         if (b >= 8'h30 && b <= 8'h39) begin
            r.dec_accum = (f.dec_accum << 3) + (f.dec_accum << 1) + {4'd0, b[3:0]};
         end else begin
            r.dec_stopped = 1'b1;
         end
      end
      dv = 1'b1;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b[3:0];
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         d = b[3:0] + 4'd9;
      end else begin
         d = 4'd0;
         dv = 1'b0;
      end
      if (!f.hex_stopped) begin
         if (dv) begin
            r.hex_accum = {f.hex_accum[3:0], d};
         end else begin
            r.hex_stopped = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic logic [3:0] encode_code(logic [7:0] hits);
      logic [3:0] code;
      code = nmea_sp_pkg::CODE_UNKNOWN;
      for (int k = 7; k >= 0; k--) begin
         if (hits[k]) begin
            code = 4'(k + 1);
         end
      end
      return code;
   endfunction

   nmea_sp_pkg::state_type  closed;
   nmea_sp_pkg::result_type field_rsp;
   nmea_sp_pkg::result_type end_rsp;
   logic                    sum_ok;
   logic                    code_marks;
   logic [6:0]              seen_upd;
   logic                    ready;
   logic [7:0]              xor_upd;

   always_comb begin
      closed = cur_state;
      if (cur_state.field_count == 8'd0 && cur_state.field.starts_dollar) begin
         closed.current_code = encode_code(cur_state.field.code_hits);
      end else if (cur_state.current_code == nmea_sp_pkg::CODE_GSV) begin
         if (cur_state.field_count == 8'd1) begin
            closed.gsv_total = cur_state.field.dec_accum;
         end else if (cur_state.field_count == 8'd2) begin
            closed.gsv_number = cur_state.field.dec_accum;
         end
      end
      closed.field_count = cur_state.field_count + 8'd1;
      closed.field = '0;

      field_rsp = '0;
      field_rsp.sentence_code = closed.current_code;
      field_rsp.field_index = cur_state.field_count;
      field_rsp.field_value = cur_state.field.dec_accum;

      sum_ok = (cur_state.field.hex_accum == cur_state.running_xor);
      code_marks = (cur_state.current_code != nmea_sp_pkg::CODE_UNKNOWN) &&
                   (cur_state.current_code <= nmea_sp_pkg::CODE_ZDA) &&
                   ((cur_state.current_code != nmea_sp_pkg::CODE_GSV) ||
                    (cur_state.gsv_number == cur_state.gsv_total));
      seen_upd = cur_state.seen_mask;
      if (sum_ok && code_marks) begin
         seen_upd = cur_state.seen_mask | (7'd1 << (cur_state.current_code - 4'd1));
      end
      ready = sum_ok && ((seen_upd & required_mask) == required_mask);

      end_rsp.event_kind = 1'b1;
      end_rsp.sentence_code = cur_state.current_code;
      end_rsp.field_index = cur_state.field_count;
      end_rsp.field_value = cur_state.field.dec_accum;
      end_rsp.checksum_ok = sum_ok;
      end_rsp.data_ready = ready;
      end_rsp.unknown_sentence = (cur_state.current_code == nmea_sp_pkg::CODE_UNKNOWN);

      xor_upd = cur_state.after_asterisk ? cur_state.running_xor
                                         : (cur_state.running_xor ^ rx_byte);

      nxt_state = cur_state;
      has_result = 1'b0;
      result = field_rsp;
      case (rx_byte)
         nmea_sp_pkg::CH_NUL: begin
         end
         nmea_sp_pkg::CH_START: begin
            nxt_state.running_xor = 8'd0;
            nxt_state.after_asterisk = 1'b0;
            nxt_state.field_count = 8'd0;
            nxt_state.current_code = nmea_sp_pkg::CODE_UNKNOWN;
            nxt_state.gsv_total = 8'd0;
            nxt_state.gsv_number = 8'd0;
            nxt_state.field = add_char('0, rx_byte);
            nxt_state.field.starts_dollar = 1'b1;
         end
         nmea_sp_pkg::CH_COMMA: begin
            nxt_state = closed;
            nxt_state.running_xor = xor_upd;
            has_result = 1'b1;
         end
         nmea_sp_pkg::CH_STAR: begin
            nxt_state = closed;
            nxt_state.after_asterisk = 1'b1;
            has_result = 1'b1;
         end
         nmea_sp_pkg::CH_CR: begin
            nxt_state.seen_mask = ready ? 7'd0 : seen_upd;
            has_result = 1'b1;
            result = end_rsp;
         end
         default: begin
            nxt_state.running_xor = xor_upd;
            nxt_state.field = add_char(cur_state.field, rx_byte);
         end
      endcase
   end

endmodule

@@ rtl/nmea_sentence_parser_core.sv @@
// NMEA 0183 sentence parser: one request byte per cycle, a response per field or sentence end.
// A request byte is registered on acceptance, stepped by nmea_sp_step, and its response registered.
// Throughput: one byte per cycle unless rsp_tready stalls; nmea_sp_step is combinational.
// Bytes that end no field or sentence produce no response.
// Reset (synchronous, active high) clears parser state and sets the required mask to all ones.
// Depends on nmea_sp_pkg, nmea_sp_step and nmea_sentence_parser_core_defines.svh.
`include "nmea_sentence_parser_core_defines.svh"

module nmea_sentence_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] field_index, [15:8] field_value,
                                    // [16] checksum_ok, [17] data_ready,
                                    // [18] unknown_sentence, [23:19] zero
   output logic [3:0]  rsp_tuser,   // [3:0] sentence_code
   output logic        rsp_tlast,   // event_kind
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // [6:0] required_mask
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [7:0]              in_byte_ff;
   nmea_sp_pkg::state_type  state_ff;
   nmea_sp_pkg::state_type  state_in;
   logic                    out_valid_ff;
   nmea_sp_pkg::result_type out_data_ff;
   logic [6:0]              required_mask_ff;
   logic                    advance;
   logic                    has_result;
   nmea_sp_pkg::result_type step_rsp;

   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);

   nmea_sp_step u_step (
      .cur_state     (state_ff),
      .rx_byte       (in_byte_ff),
      .required_mask (required_mask_ff),
      .nxt_state     (state_in),
      .has_result    (has_result),
      .result        (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
         required_mask_ff <= nmea_sp_pkg::REQUIRED_MASK_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && has_result;
            if (in_valid_ff) begin
               state_ff <= state_in;
            end
         end
         if (csr_wr_en) begin
            required_mask_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && in_valid_ff && has_result) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast = out_data_ff.event_kind;
   assign rsp_tuser = out_data_ff.sentence_code;
   assign rsp_tdata = {5'd0, out_data_ff.unknown_sentence, out_data_ff.data_ready,
                       out_data_ff.checksum_ok, out_data_ff.field_value,
                       out_data_ff.field_index};

   `NSP_ASSERT_SAME(a_ready_needs_ok, out_valid_ff && out_data_ff.data_ready,
                    out_data_ff.checksum_ok && out_data_ff.event_kind)
   `NSP_ASSERT_SAME(a_field_flags_low, out_valid_ff && !out_data_ff.event_kind,
                    !out_data_ff.checksum_ok && !out_data_ff.data_ready &&
                    !out_data_ff.unknown_sentence)
   `NSP_ASSERT_NEXT(a_seen_cleared,
                    advance && in_valid_ff && has_result && step_rsp.data_ready,
                    state_ff.seen_mask == 7'd0)
   `NSP_ASSERT_SAME(a_code_range, out_valid_ff,
                    out_data_ff.sentence_code <= nmea_sp_pkg::CODE_TXT)

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for nmea_sentence_parser_core: NMEA text is streamed in byte by byte
// and every response is checked against a predictor held in a small scoreboard class.
// Depends on nmea_sp_pkg and the parser RTL.

module tb;
   import nmea_sp_pkg::*;

   localparam int ITEMS        = 1800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   class nmea_scoreboard;
      logic [6:0]  required_mask;
      logic [7:0]  xor_sum;
      logic        past_star;
      logic [7:0]  field_num;
      logic [3:0]  code;
      logic [7:0]  gsv_parts;
      logic [7:0]  gsv_part_no;
      logic [6:0]  seen;
      logic        starts_dollar;
      logic [15:0] last_two;
      logic [7:0]  name_hits;
      logic [7:0]  dec_val;
      logic        dec_done;
      logic [7:0]  hex_val;
      logic        hex_done;
      result_type  expected_q[$];
      int          errors;

      function new();
         required_mask = REQUIRED_MASK_RESET;
         xor_sum = '0;
         past_star = 1'b0;
         field_num = '0;
         code = CODE_UNKNOWN;
         gsv_parts = '0;
         gsv_part_no = '0;
         seen = '0;
         errors = 0;
         clear_field();
      endfunction

      function void clear_field();
         starts_dollar = 1'b0;
         last_two = '0;
         name_hits = '0;
         dec_val = '0;
         dec_done = 1'b0;
         hex_val = '0;
         hex_done = 1'b0;
      endfunction

      function void take_char(logic [7:0] b);
         logic [4:0] digit;
         for (int k = 0; k < 8; k++)
            if ({last_two, b} == NAME_TABLE[k]) name_hits[k] = 1'b1;
         last_two = {last_two[7:0], b};
         if (!dec_done) begin
            if (b >= "0" && b <= "9") dec_val = dec_val * 8'd10 + (b - "0");
            else dec_done = 1'b1;
         end
         digit = 5'd16;
         if (b >= "0" && b <= "9") digit = 5'(b - "0");
         else if (b >= "a" && b <= "f") digit = 5'(b - "a" + 10);
         else if (b >= "A" && b <= "F") digit = 5'(b - "A" + 10);
         if (!hex_done) begin
            if (digit < 5'd16) hex_val = {hex_val[3:0], digit[3:0]};
            else hex_done = 1'b1;
         end
      endfunction

      function result_type close_field();
         result_type r;
         if (field_num == 8'd0 && starts_dollar) begin
            code = CODE_UNKNOWN;
            for (int k = 7; k >= 0; k--)
               if (name_hits[k]) code = 4'(k + 1);
         end else if (code == CODE_GSV) begin
            if (field_num == 8'd1) gsv_parts = dec_val;
            else if (field_num == 8'd2) gsv_part_no = dec_val;
         end
         r = '0;
         r.sentence_code = code;
         r.field_index = field_num;
         r.field_value = dec_val;
         field_num = field_num + 8'd1;
         clear_field();
         return r;
      endfunction

      function void note_request(logic [7:0] b);
         result_type r;
         logic ok;
         if (b == CH_NUL) return;
         case (b)
            CH_START: begin
               past_star = 1'b0;
               field_num = '0;
               code = CODE_UNKNOWN;
               xor_sum = '0;
               gsv_parts = '0;
               gsv_part_no = '0;
               clear_field();
               take_char(b);
               starts_dollar = 1'b1;
            end
            CH_COMMA: begin
               if (!past_star) xor_sum ^= b;
               expected_q.push_back(close_field());
            end
            CH_STAR: begin
               expected_q.push_back(close_field());
               past_star = 1'b1;
            end
            CH_CR: begin
               ok = (hex_val == xor_sum);
               r = '0;
               r.event_kind = 1'b1;
               r.sentence_code = code;
               r.field_index = field_num;
               r.field_value = dec_val;
               r.checksum_ok = ok;
               r.unknown_sentence = (code == CODE_UNKNOWN);
               if (ok) begin
                  if (code != CODE_UNKNOWN && code <= CODE_ZDA &&
                      (code != CODE_GSV || gsv_part_no == gsv_parts))
                     seen[code - 4'd1] = 1'b1;
                  if ((seen & required_mask) == required_mask) begin
                     r.data_ready = 1'b1;
                     seen = '0;
                  end
               end
               expected_q.push_back(r);
            end
            default: begin
               if (!past_star) xor_sum ^= b;
               take_char(b);
            end
         endcase
      endfunction

      function void compare(string label, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", label, want, got);
            errors++;
         end
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare("event_kind", want.event_kind, got.event_kind);
         compare("sentence_code", want.sentence_code, got.sentence_code);
         compare("field_index", want.field_index, got.field_index);
         compare("field_value", want.field_value, got.field_value);
         compare("checksum_ok", want.checksum_ok, got.checksum_ok);
         compare("data_ready", want.data_ready, got.data_ready);
         compare("unknown_sentence", want.unknown_sentence, got.unknown_sentence);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   nmea_scoreboard sb = new();
   logic [7:0]     line_q[$];
   int             bytes_sent = 0;
   int             burst_left = 0;
   bit             gap_off = 1'b0;
   int             cycles = 0;
   int             responses = 0;
   int             hold_left = 0;
   int             rx_mode = 0;
   int             mode_left = 0;
   bit             ready_next;

   nmea_sentence_parser_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The receiver changes its stall pattern every so often and twice holds off for a long time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response({rsp_tlast, rsp_tuser, rsp_tdata[7:0], rsp_tdata[15:8],
                               rsp_tdata[16], rsp_tdata[17], rsp_tdata[18]});
            responses++;
            if (responses == 150 || responses == 400) hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (rx_mode)
               0: ready_next = 1'b1;
               1: ready_next = $urandom_range(0, 1);
               2: ready_next = ($urandom_range(0, 4) == 0);
               default: ready_next = (mode_left % 5 != 0);
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!gap_off && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b);
      if (b != CH_NUL) bytes_sent++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i]);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [6:0] m);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.required_mask = m;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
      if (nib < 4'd10) return 8'("0" + nib);
      return lower ? 8'("a" + nib - 10) : 8'("A" + nib - 10);
   endfunction

   function automatic logic [7:0] rand_upper();
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic void push_str(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   function automatic void push_name(input int k);
      logic [23:0] n;
      n = NAME_TABLE[k - 1];
      line_q.push_back(n[23:16]);
      line_q.push_back(n[15:8]);
      line_q.push_back(n[7:0]);
   endfunction

   function automatic void push_field();
      string letters;
      letters = "NSEWAV";
      case ($urandom_range(0, 5))
         0: ;
         1, 2: begin
            repeat ($urandom_range(1, 5)) line_q.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               line_q.push_back(".");
               repeat (2) line_q.push_back(8'("0" + $urandom_range(0, 9)));
            end
         end
         3: line_q.push_back(letters[$urandom_range(0, 5)]);
         4: repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
         default: begin
            repeat ($urandom_range(1, 3))
               line_q.push_back(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1)));
         end
      endcase
   endfunction

   // Appends the asterisk and up to two checksum digits: the XOR of everything after the dollar sign, XORed with flip.
   function automatic void close_line(input bit lower, input logic [7:0] flip, input int digits);
      logic [7:0] sum;
      sum = flip;
      for (int i = 1; i < line_q.size(); i++) sum ^= line_q[i];
      line_q.push_back(CH_STAR);
      if (digits > 1) line_q.push_back(hex_char(sum[7:4], lower));
      if (digits > 0) line_q.push_back(hex_char(sum[3:0], lower));
   endfunction

   function automatic void build_sentence(input logic [3:0] kind, input int nfields,
                                          input bit bare);
      int total;
      int part;
      line_q.delete();
      line_q.push_back(CH_START);
      if ($urandom_range(0, 4) != 0) begin
         line_q.push_back(rand_upper());
         line_q.push_back(rand_upper());
      end
      if (kind == CODE_UNKNOWN) repeat (3) line_q.push_back(rand_upper());
      else push_name(kind);
      if ($urandom_range(0, 7) == 0) push_name($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) line_q.push_back(rand_upper());
      total = $urandom_range(1, 4);
      part = $urandom_range(0, 1) ? total : $urandom_range(1, 5);
      for (int f = 1; f <= nfields; f++) begin
         line_q.push_back(CH_COMMA);
         if (bare) continue;
         if (kind == CODE_GSV && f == 1) push_str($sformatf("%0d", total));
         else if (kind == CODE_GSV && f == 2) push_str($sformatf("%0d", part));
         else push_field();
      end
      close_line($urandom_range(0, 1), ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
      if ($urandom_range(0, 15) == 0) begin
         line_q.push_back(CH_COMMA);
         push_field();
      end
      line_q.push_back(CH_CR);
      if ($urandom_range(0, 9) == 0) line_q.push_back(CH_CR);
      line_q.push_back(8'h0A);
   endfunction

   initial begin
      logic [6:0] masks[6];
      logic [3:0] kind;
      int         rot;
      int         phase_end;
      int         r;
      int         cut;
      masks = '{7'h00, 7'h01, 7'h7F, 7'h40, 7'h00, 7'h7F};
      masks[4] = 7'($urandom_range(0, 127));
      rot = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(CH_NUL);
      send_byte(8'hFF);
      line_q.delete();
      push_str("$GSV,1,1");
      close_line(1'b0, 8'h00, 2);
      line_q.push_back(CH_CR);
      send_line();
      send_byte(CH_CR);
      line_q.delete();
      push_str("$XTXTGGA,999");
      close_line(1'b1, 8'h00, 2);
      line_q.push_back(CH_CR);
      send_line();

      for (int p = 0; p < 6; p++) begin
         write_mask(masks[p]);
         gap_off = (p == 3);
         phase_end = bytes_sent + ITEMS / 6;
         if (p == 2) begin
            build_sentence(4'd2, 300, 1'b1);
            send_line();
         end
         while (bytes_sent < phase_end) begin
            if ($urandom_range(0, 1)) begin
               kind = 4'(rot % 7 + 1);
               rot++;
            end else begin
               kind = 4'($urandom_range(0, 8));
            end
            build_sentence(kind, (kind == CODE_GSV) ? $urandom_range(2, 6) : $urandom_range(0, 6),
                           1'b0);
            r = $urandom_range(0, 19);
            if (r == 0) begin
               line_q.pop_front();
            end else if (r == 1) begin
               line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(1, 255));
            end else if (r == 2) begin
               line_q.insert($urandom_range(0, line_q.size() - 1), CH_NUL);
            end else if (r == 3) begin
               line_q.delete();
               repeat ($urandom_range(3, 30)) line_q.push_back(8'($urandom_range(0, 255)));
            end else if (r == 4) begin
               cut = $urandom_range(1, line_q.size() - 1);
               while (line_q.size() > cut) line_q.pop_back();
            end
            send_line();
         end
      end

      drain();
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
